/* rtl/fraction_arith_reduce_unit_macros.svh */
// Assertion macros for the fraction arithmetic unit.
// Needs a clock named clk and a reset named rst in the using module.
`ifndef FRACTION_ARITH_REDUCE_UNIT_MACROS_SVH
`define FRACTION_ARITH_REDUCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FARU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`define FARU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define FARU_ASSERT_NEXT(lbl, ante, cons)
`define FARU_ASSERT_SAME(lbl, ante, cons)
`endif
`endif

/* rtl/faru_pkg.sv */
// Shared types for the fraction arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package faru_pkg;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_INC = 3'd4,
    KIND_DEC = 3'd5,
    KIND_CMP = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    MSEL_FIRST  = 2'd0,
    MSEL_SECOND = 2'd1,
    MSEL_DEN    = 2'd2
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_FORM, S_GCD, S_DINIT, S_DIV, S_FIN, S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     form;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic reduce;
    logic gcd_done;
  } status_t;

endpackage
`default_nettype wire

/* rtl/fraction_arith_reduce_unit.sv */
// Top level of the fraction arithmetic unit with GCD reduction.
// Depends on faru_pkg, faru_ctrl, faru_dp and the assertion macro header.
//
//   channel   handshake      fields
//   input     start / busy   kind, num_a, den_a, num_b, den_b
//   result    done strobe    result_num, result_den, is_less, is_equal,
//                            is_greater, zero_den
//
// An item passes the multiply states S_MUL0, S_MUL1 and S_MUL2 on one shared
// multiplier, a form step, a binary GCD of one step per cycle (up to about 4*W
// steps, W = 2*VALUE_WIDTH+1 capped at 64), then W steps of two parallel
// restoring dividers and the result states S_FIN and S_DONE. Unreduced kinds
// skip GCD and divide. busy is high from acceptance to the done strobe.
// Synchronous reset returns the controller to idle. No output stall: the
// receiver takes each result in its done cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "fraction_arith_reduce_unit_macros.svh"
module fraction_arith_reduce_unit #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    kind,
  input  wire logic signed [VALUE_WIDTH-1:0] num_a,
  input  wire logic signed [VALUE_WIDTH-1:0] den_a,
  input  wire logic signed [VALUE_WIDTH-1:0] num_b,
  input  wire logic signed [VALUE_WIDTH-1:0] den_b,
  output logic                               done,
  output logic signed [32:0]                 result_num,
  output logic signed [31:0]                 result_den,
  output logic                               is_less,
  output logic                               is_equal,
  output logic                               is_greater,
  output logic                               zero_den
);

  faru_pkg::cmd_t    cmd;
  faru_pkg::status_t status;

  faru_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  faru_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .kind       (kind),
    .num_a      (num_a),
    .den_a      (den_a),
    .num_b      (num_b),
    .den_b      (den_b),
    .result_num (result_num),
    .result_den (result_den),
    .is_less    (is_less),
    .is_equal   (is_equal),
    .is_greater (is_greater),
    .zero_den   (zero_den)
  );

  `FARU_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `FARU_ASSERT_NEXT(a_done_single, done, !done && !busy)
  `FARU_ASSERT_SAME(a_done_busy, done, busy)

endmodule
`default_nettype wire

/* rtl/faru_dp.sv */
// Datapath: operand registers, shared multiplier, binary GCD and two dividers.
// Depends on faru_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fraction_arith_reduce_unit_macros.svh"
module faru_dp #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire faru_pkg::cmd_t                cmd,
  output faru_pkg::status_t                  status,
  input  wire logic [2:0]                    kind,
  input  wire logic signed [VALUE_WIDTH-1:0] num_a,
  input  wire logic signed [VALUE_WIDTH-1:0] den_a,
  input  wire logic signed [VALUE_WIDTH-1:0] num_b,
  input  wire logic signed [VALUE_WIDTH-1:0] den_b,
  output logic signed [32:0]                 result_num,
  output logic signed [31:0]                 result_den,
  output logic                               is_less,
  output logic                               is_equal,
  output logic                               is_greater,
  output logic                               zero_den
);

  localparam int PW = (2 * VALUE_WIDTH + 1 > 64) ? 64 : 2 * VALUE_WIDTH + 1;
  localparam int KW = $clog2(PW);
  localparam int MW = 2 * VALUE_WIDTH;

  logic [2:0]                    kind_r;
  logic signed [VALUE_WIDTH-1:0] na, da, nb, db;
  logic signed [MW-1:0]          p0, p1, p2;
  logic signed [PW-1:0]          rn, rd;
  logic                          sn, sd, reduce;
  logic [PW-1:0]                 ga, gb, g, qn, qd;
  logic [PW-1:0]                 remn, remd;
  logic [KW-1:0]                 k;
  logic                          lt, eq, gt;

  logic signed [VALUE_WIDTH-1:0] mul_a, mul_b;
  logic signed [MW-1:0]          prod;
  logic signed [PW-1:0]          rn_form, rd_form, rn_fin, rd_fin;
  logic [PW-1:0]                 mag_n, mag_d;
  logic [PW:0]                   shn, shd;

  always_comb begin
    unique case (cmd.mul_sel)
      faru_pkg::MSEL_FIRST: begin
        mul_a = na;
        mul_b = (kind_r == faru_pkg::KIND_MUL) ? nb : db;
      end
      faru_pkg::MSEL_SECOND: begin
        mul_a = nb;
        mul_b = da;
      end
      default: begin
        mul_a = da;
        mul_b = (kind_r == faru_pkg::KIND_DIV) ? nb : db;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    unique case (kind_r)
      faru_pkg::KIND_ADD: begin
        rn_form = PW'(p0) + PW'(p1);
        rd_form = PW'(p2);
      end
      faru_pkg::KIND_SUB: begin
        rn_form = PW'(p0) - PW'(p1);
        rd_form = PW'(p2);
      end
      faru_pkg::KIND_MUL, faru_pkg::KIND_DIV: begin
        rn_form = PW'(p0);
        rd_form = PW'(p2);
      end
      faru_pkg::KIND_INC: begin
        rn_form = PW'(na) + PW'(da);
        rd_form = PW'(da);
      end
      faru_pkg::KIND_DEC: begin
        rn_form = PW'(na) - PW'(da);
        rd_form = PW'(da);
      end
      default: begin
        rn_form = '0;
        rd_form = '0;
      end
    endcase
  end

  assign mag_n = rn_form[PW-1] ? PW'(-rn_form) : PW'(rn_form);
  assign mag_d = rd_form[PW-1] ? PW'(-rd_form) : PW'(rd_form);
  assign shn   = {remn, qn[PW-1]};
  assign shd   = {remd, qd[PW-1]};

  assign rn_fin = reduce ? (sn ? -$signed(qn) : $signed(qn)) : rn;
  assign rd_fin = reduce ? (sd ? -$signed(qd) : $signed(qd)) : rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce <= 1'b0;
    end else if (cmd.form) begin
      reduce <= (kind_r <= 3'(faru_pkg::KIND_DIV));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      na     <= num_a;
      da     <= den_a;
      nb     <= num_b;
      db     <= den_b;
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        faru_pkg::MSEL_FIRST:  p0 <= prod;
        faru_pkg::MSEL_SECOND: p1 <= prod;
        default:               p2 <= prod;
      endcase
    end
    if (cmd.form) begin
      rn <= rn_form;
      rd <= rd_form;
      sn <= rn_form[PW-1];
      sd <= rd_form[PW-1];
      ga <= (mag_n == '0 && mag_d == '0) ? PW'(1) : mag_n;
      gb <= mag_d;
      k  <= '0;
      lt <= (kind_r == faru_pkg::KIND_CMP) && (p0 < p1);
      eq <= (kind_r == faru_pkg::KIND_CMP) && (p0 == p1);
      gt <= (kind_r == faru_pkg::KIND_CMP) && (p0 > p1);
    end
    if (cmd.gcd_step) begin
      priority if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        k  <= k + KW'(1);
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= ga - gb;
      end else begin
        gb <= gb - ga;
      end
    end
    if (cmd.div_init) begin
      g    <= (ga | gb) << k;
      qn   <= sn ? PW'(-rn) : PW'(rn);
      qd   <= sd ? PW'(-rd) : PW'(rd);
      remn <= '0;
      remd <= '0;
    end
    if (cmd.div_step) begin
      if (shn >= {1'b0, g}) begin
        remn <= PW'(shn - {1'b0, g});
        qn   <= {qn[PW-2:0], 1'b1};
      end else begin
        remn <= shn[PW-1:0];
        qn   <= {qn[PW-2:0], 1'b0};
      end
      if (shd >= {1'b0, g}) begin
        remd <= PW'(shd - {1'b0, g});
        qd   <= {qd[PW-2:0], 1'b1};
      end else begin
        remd <= shd[PW-1:0];
        qd   <= {qd[PW-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      result_num <= 33'(rn_fin);
      result_den <= 32'(rd_fin);
      is_less    <= lt;
      is_equal   <= eq;
      is_greater <= gt;
      zero_den   <= (kind_r <= 3'(faru_pkg::KIND_DEC)) && (rd_fin == '0);
    end
  end

  assign status.reduce   = reduce;
  assign status.gcd_done = (ga == '0) || (gb == '0);

  `FARU_ASSERT_SAME(a_gcd_live, cmd.gcd_step, (ga != '0) && (gb != '0))

endmodule
`default_nettype wire

/* rtl/faru_ctrl.sv */
// Controller: sequences multiply, form, GCD, divide and result steps.
// Depends on faru_pkg.
`timescale 1ns / 1ps
`default_nettype none
module faru_ctrl #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output faru_pkg::cmd_t         cmd,
  input  wire faru_pkg::status_t status
);

  localparam int PW = (2 * VALUE_WIDTH + 1 > 64) ? 64 : 2 * VALUE_WIDTH + 1;
  localparam int CW = $clog2(PW);

  faru_pkg::state_t state, state_next;
  logic [CW-1:0]    cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= faru_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel = faru_pkg::MSEL_FIRST;
    unique case (state)
      faru_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = faru_pkg::S_MUL0;
        end
      end
      faru_pkg::S_MUL0: begin
        cmd.mul_en = 1'b1;
        state_next = faru_pkg::S_MUL1;
      end
      faru_pkg::S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = faru_pkg::MSEL_SECOND;
        state_next  = faru_pkg::S_MUL2;
      end
      faru_pkg::S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = faru_pkg::MSEL_DEN;
        state_next  = faru_pkg::S_FORM;
      end
      faru_pkg::S_FORM: begin
        cmd.form   = 1'b1;
        state_next = faru_pkg::S_GCD;
      end
      faru_pkg::S_GCD: begin
        priority if (!status.reduce) begin
          state_next = faru_pkg::S_FIN;
        end else if (status.gcd_done) begin
          state_next = faru_pkg::S_DINIT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      faru_pkg::S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = faru_pkg::S_DIV;
      end
      faru_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CW'(1);
        if (cnt == CW'(PW - 1)) begin
          state_next = faru_pkg::S_FIN;
        end
      end
      faru_pkg::S_FIN: begin
        cmd.finish = 1'b1;
        state_next = faru_pkg::S_DONE;
      end
      default: begin
        state_next = faru_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != faru_pkg::S_IDLE);
  assign done = (state == faru_pkg::S_DONE);

endmodule
`default_nettype wire
